/* rtl/bsdf_pkg.sv */
package bsdf_pkg;

   // Field widths.
   localparam int CoordW  = 32;
   localparam int DiffW   = 33;
   localparam int MagW    = 32;
   localparam int SqW     = 64;
   localparam int RadW    = 66;
   localparam int RootW   = 33;
   localparam int RemW    = 36;
   localparam int DirW    = 31;
   localparam int DivRemW = 35;
   localparam int ForceW  = 48;
   localparam int StiffW  = 40;
   localparam int DampW   = 24;
   localparam int RestW   = 32;
   localparam int CoefW   = 64;
   localparam int CsrIdxW = 2;

   // Iteration layout of the root and divide pipelines.
   localparam int SqrtSteps  = 33;
   localparam int SqrtPer    = 3;
   localparam int SqrtStages = 11;
   localparam int DivSteps   = 31;
   localparam int DivPer     = 3;
   localparam int DivStages  = 11;

   // Register indexes.
   localparam logic [CsrIdxW-1:0] CSR_STIFFNESS = 2'd0;
   localparam logic [CsrIdxW-1:0] CSR_DAMPING   = 2'd1;
   localparam logic [CsrIdxW-1:0] CSR_REST      = 2'd2;

   localparam logic [StiffW-1:0] STIFF_RESET = 40'd256000;
   localparam logic [DampW-1:0]  DAMP_RESET  = 24'd655;
   localparam logic [RestW-1:0]  REST_RESET  = 32'd65536;

   localparam logic [DirW-1:0] DIR_ONE = 31'h4000_0000;

   typedef struct packed {
      logic signed [CoordW-1:0] pos_a_x;
      logic signed [CoordW-1:0] pos_a_y;
      logic signed [CoordW-1:0] pos_a_z;
      logic signed [CoordW-1:0] pos_b_x;
      logic signed [CoordW-1:0] pos_b_y;
      logic signed [CoordW-1:0] pos_b_z;
      logic signed [CoordW-1:0] vel_a_x;
      logic signed [CoordW-1:0] vel_a_y;
      logic signed [CoordW-1:0] vel_a_z;
      logic signed [CoordW-1:0] vel_b_x;
      logic signed [CoordW-1:0] vel_b_y;
      logic signed [CoordW-1:0] vel_b_z;
   } req_type;

   typedef struct packed {
      logic signed [ForceW-1:0] force_a_x;
      logic signed [ForceW-1:0] force_a_y;
      logic signed [ForceW-1:0] force_a_z;
      logic signed [ForceW-1:0] force_b_x;
      logic signed [ForceW-1:0] force_b_y;
      logic signed [ForceW-1:0] force_b_z;
      logic signed [ForceW-1:0] axial_force;
      logic                     degenerate;
   } rsp_type;

   // Geometry of one bar, handed from the front end to the force stages.
   typedef struct packed {
      logic [RootW-1:0]        len;
      logic [2:0][DirW-1:0]    dir_mag;
      logic [2:0]              dir_neg;
      logic [2:0][DiffW-1:0]   dvel;
      logic                    degenerate;
   } geom_type;

   typedef struct packed {
      logic [RemW-1:0]  rem;
      logic [RootW-1:0] root;
   } root_state_type;

   typedef struct packed {
      logic [DivRemW-1:0] rem;
      logic [DirW-1:0]    quo;
   } div_state_type;

   // One digit of the restoring square root.
   function automatic root_state_type sqrt_step(root_state_type s, logic [1:0] pair);
      root_state_type r;
      logic [RemW-1:0] shifted;
      logic [RemW-1:0] trial;
      shifted = {s.rem[RemW-3:0], pair};
      trial   = {1'b0, s.root, 2'b01};
      if (shifted >= trial) begin
         r.rem  = shifted - trial;
         r.root = {s.root[RootW-2:0], 1'b1};
      end else begin
         r.rem  = shifted;
         r.root = {s.root[RootW-2:0], 1'b0};
      end
      return r;
   endfunction

   // One bit of the restoring divide.
   function automatic div_state_type div_step(div_state_type s, logic bit_in,
                                              logic [RootW-1:0] den);
      div_state_type r;
      logic [DivRemW-1:0] shifted;
      shifted = {s.rem[DivRemW-2:0], bit_in};
      if (shifted >= {{(DivRemW-RootW){1'b0}}, den}) begin
         r.rem = shifted - {{(DivRemW-RootW){1'b0}}, den};
         r.quo = {s.quo[DirW-2:0], 1'b1};
      end else begin
         r.rem = shifted;
         r.quo = {s.quo[DirW-2:0], 1'b0};
      end
      return r;
   endfunction

endpackage

/* rtl/bsdf_geom.sv */
module bsdf_geom (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   input  bsdf_pkg::req_type  in_data,
   output logic               out_valid,
   output bsdf_pkg::geom_type out_data
);
   import bsdf_pkg::*;

   logic [CoordW-1:0] pa [3];
   logic [CoordW-1:0] pb [3];
   logic [CoordW-1:0] va [3];
   logic [CoordW-1:0] vb [3];

   assign pa[0] = in_data.pos_a_x;
   assign pa[1] = in_data.pos_a_y;
   assign pa[2] = in_data.pos_a_z;
   assign pb[0] = in_data.pos_b_x;
   assign pb[1] = in_data.pos_b_y;
   assign pb[2] = in_data.pos_b_z;
   assign va[0] = in_data.vel_a_x;
   assign va[1] = in_data.vel_a_y;
   assign va[2] = in_data.vel_a_z;
   assign vb[0] = in_data.vel_b_x;
   assign vb[1] = in_data.vel_b_y;
   assign vb[2] = in_data.vel_b_z;

   logic             v1_ff;
   logic             v2_ff;
   logic [DiffW-1:0] d1_ff    [3];
   logic [DiffW-1:0] dvel1_ff [3];
   logic [MagW-1:0]  mag2_ff  [3];
   logic             neg2_ff  [3];
   logic [SqW-1:0]   sq2_ff   [3];
   logic [DiffW-1:0] dvel2_ff [3];

   // Root pipeline; entry 0 holds the summed radicand.
   logic             sq_valid_ff [SqrtStages+1];
   root_state_type   sq_state_ff [SqrtStages+1];
   logic [RadW-1:0]  sq_rad_ff   [SqrtStages+1];
   logic [MagW-1:0]  sq_mag_ff   [SqrtStages+1][3];
   logic             sq_neg_ff   [SqrtStages+1][3];
   logic [DiffW-1:0] sq_dvel_ff  [SqrtStages+1][3];

   // Divide pipeline; entry 0 holds the starting remainders.
   logic             dq_valid_ff [DivStages+1];
   div_state_type    dq_state_ff [DivStages+1][3];
   logic [RootW-1:0] dq_len_ff   [DivStages+1];
   logic             dq_bit_ff   [DivStages+1][3];
   logic             dq_neg_ff   [DivStages+1][3];
   logic [DiffW-1:0] dq_dvel_ff  [DivStages+1][3];

   // Valid bits of the front stages.
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff          <= 1'b0;
         v2_ff          <= 1'b0;
         sq_valid_ff[0] <= 1'b0;
         dq_valid_ff[0] <= 1'b0;
      end else begin
         v1_ff          <= in_valid;
         v2_ff          <= v1_ff;
         sq_valid_ff[0] <= v2_ff;
         dq_valid_ff[0] <= sq_valid_ff[SqrtStages];
      end
   end

   // Differences, squares and their sum.
   always_ff @(posedge clock) begin
      logic [DiffW-1:0] m;
      for (int i = 0; i < 3; i++) begin
         d1_ff[i]    <= {pb[i][CoordW-1], pb[i]} - {pa[i][CoordW-1], pa[i]};
         dvel1_ff[i] <= {vb[i][CoordW-1], vb[i]} - {va[i][CoordW-1], va[i]};
         m = d1_ff[i][DiffW-1] ? (~d1_ff[i] + 1'b1) : d1_ff[i];
         mag2_ff[i]  <= m[MagW-1:0];
         neg2_ff[i]  <= d1_ff[i][DiffW-1];
         sq2_ff[i]   <= m[MagW-1:0] * m[MagW-1:0];
         dvel2_ff[i] <= dvel1_ff[i];
         sq_mag_ff[0][i]  <= mag2_ff[i];
         sq_neg_ff[0][i]  <= neg2_ff[i];
         sq_dvel_ff[0][i] <= dvel2_ff[i];
      end
      sq_rad_ff[0]   <= RadW'(sq2_ff[0]) + RadW'(sq2_ff[1]) + RadW'(sq2_ff[2]);
      sq_state_ff[0] <= '0;
   end

   // Square root, three digits a stage.
   for (genvar j = 0; j < SqrtStages; j++) begin : g_root
      root_state_type st;
      always_comb begin
         st = sq_state_ff[j];
         for (int k = 0; k < SqrtPer; k++) begin
            st = sqrt_step(st, sq_rad_ff[j][2*(SqrtSteps-1-SqrtPer*j-k) +: 2]);
         end
      end
      always_ff @(posedge clock) begin
         if (reset) sq_valid_ff[j+1] <= 1'b0;
         else       sq_valid_ff[j+1] <= sq_valid_ff[j];
      end
      always_ff @(posedge clock) begin
         sq_state_ff[j+1] <= st;
         sq_rad_ff[j+1]   <= sq_rad_ff[j];
         for (int i = 0; i < 3; i++) begin
            sq_mag_ff[j+1][i]  <= sq_mag_ff[j][i];
            sq_neg_ff[j+1][i]  <= sq_neg_ff[j][i];
            sq_dvel_ff[j+1][i] <= sq_dvel_ff[j][i];
         end
      end
   end

   // The top of each dividend is |d|/2; the first dividend bit shifted in is |d| bit 0.
   always_ff @(posedge clock) begin
      dq_len_ff[0] <= sq_state_ff[SqrtStages].root;
      for (int i = 0; i < 3; i++) begin
         dq_state_ff[0][i].rem <= {{(DivRemW-MagW+1){1'b0}}, sq_mag_ff[SqrtStages][i][MagW-1:1]};
         dq_state_ff[0][i].quo <= '0;
         dq_bit_ff[0][i]       <= sq_mag_ff[SqrtStages][i][0];
         dq_neg_ff[0][i]       <= sq_neg_ff[SqrtStages][i];
         dq_dvel_ff[0][i]      <= sq_dvel_ff[SqrtStages][i];
      end
   end

   // Direction components, up to three quotient bits a stage.
   for (genvar j = 0; j < DivStages; j++) begin : g_div
      div_state_type st [3];
      always_comb begin
         int b;
         for (int i = 0; i < 3; i++) begin
            st[i] = dq_state_ff[j][i];
            for (int k = 0; k < DivPer; k++) begin
               b = DivSteps - 1 - DivPer * j - k;
               if (b >= 0) begin
                  st[i] = div_step(st[i], (b == DivSteps - 1) ? dq_bit_ff[j][i] : 1'b0,
                                   dq_len_ff[j]);
               end
            end
         end
      end
      always_ff @(posedge clock) begin
         if (reset) dq_valid_ff[j+1] <= 1'b0;
         else       dq_valid_ff[j+1] <= dq_valid_ff[j];
      end
      always_ff @(posedge clock) begin
         dq_len_ff[j+1] <= dq_len_ff[j];
         for (int i = 0; i < 3; i++) begin
            dq_state_ff[j+1][i] <= st[i];
            dq_bit_ff[j+1][i]   <= dq_bit_ff[j][i];
            dq_neg_ff[j+1][i]   <= dq_neg_ff[j][i];
            dq_dvel_ff[j+1][i]  <= dq_dvel_ff[j][i];
         end
      end
   end

   // A zero-length bar points along x.
   always_comb begin
      logic deg;
      deg = (dq_len_ff[DivStages] == '0);
      out_valid           = dq_valid_ff[DivStages];
      out_data.len        = dq_len_ff[DivStages];
      out_data.degenerate = deg;
      for (int i = 0; i < 3; i++) begin
         out_data.dvel[i] = dq_dvel_ff[DivStages][i];
         if (deg) begin
            out_data.dir_mag[i] = (i == 0) ? DIR_ONE : '0;
            out_data.dir_neg[i] = 1'b0;
         end else begin
            out_data.dir_mag[i] = dq_state_ff[DivStages][i].quo;
            out_data.dir_neg[i] = dq_neg_ff[DivStages][i];
         end
      end
   end

endmodule

/* rtl/bar_spring_damper_force_top.sv */
// Channel  | Ports                                     | Direction
// request  | start, busy, req_data                     | in (busy is always low)
// response | rsp_valid, rsp_data                       | out, one-cycle strobe
// config   | csr_write_en, csr_index, csr_wdata        | in, write only
//
// One item is taken in every cycle; each result passes through the 33-digit root
// and 31-bit divide pipelines before it appears.
// Reset clears the valid bits and loads the register defaults.
// The pipeline never stalls, since the receiver takes every strobe.
module bar_spring_damper_force_top (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   output logic                             busy,
   input  bsdf_pkg::req_type                req_data,
   output logic                             rsp_valid,
   output bsdf_pkg::rsp_type                rsp_data,
   input  logic                             csr_write_en,
   input  logic [bsdf_pkg::CsrIdxW-1:0]     csr_index,
   input  logic [bsdf_pkg::StiffW-1:0]      csr_wdata
);
   import bsdf_pkg::*;

   localparam logic [60:0] CAP60 = 61'h1000_0000_0000_0000;
   localparam logic signed [62:0] POS48 = 63'sh7FFF_FFFF_FFFF;
   localparam logic signed [62:0] NEG48 = -63'sh8000_0000_0000;
   localparam logic [ForceW-1:0] POS_F = 48'h7FFF_FFFF_FFFF;
   localparam logic [ForceW-1:0] NEG_F = 48'h8000_0000_0000;

   assign busy = 1'b0;

   logic [StiffW-1:0] stiff_ff;
   logic [DampW-1:0]  damp_ff;
   logic [RestW-1:0]  rest_ff;
   logic [43:0]       coef_lo_ff;
   logic [43:0]       coef_hi_ff;
   logic [CoefW-1:0]  coef_ff;

   // Register writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         stiff_ff <= STIFF_RESET;
         damp_ff  <= DAMP_RESET;
         rest_ff  <= REST_RESET;
      end else if (csr_write_en) begin
         case (csr_index)
            CSR_STIFFNESS: stiff_ff <= csr_wdata;
            CSR_DAMPING:   damp_ff  <= csr_wdata[DampW-1:0];
            CSR_REST:      rest_ff  <= csr_wdata[RestW-1:0];
            default:       ;
         endcase
      end
   end

   // Damping coefficient follows the registers in two steps.
   always_ff @(posedge clock) begin
      coef_lo_ff <= damp_ff * stiff_ff[19:0];
      coef_hi_ff <= damp_ff * stiff_ff[39:20];
      coef_ff    <= CoefW'(coef_lo_ff) + (CoefW'(coef_hi_ff) << 20);
   end

   logic     g_valid;
   geom_type g_data;

   bsdf_geom u_geom (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (start && !busy),
      .in_data   (req_data),
      .out_valid (g_valid),
      .out_data  (g_data)
   );

   logic [7:0] v_ff;

   always_ff @(posedge clock) begin
      if (reset) v_ff <= '0;
      else       v_ff <= {v_ff[6:0], g_valid};
   end

   logic [62:0]        p0_ff [3];
   logic               pneg0_ff [3];
   logic signed [34:0] st0_ff, st1_ff;
   logic signed [35:0] ldt1_ff;
   logic [53:0]        ek_lo2_ff, ek_hi2_ff;
   logic [49:0]        dk_pp2_ff [4];
   logic               eneg2_ff, dneg2_ff, eneg3_ff, dneg3_ff;
   logic [73:0]        ek_prod3_ff;
   logic [98:0]        dk_prod3_ff;
   logic signed [61:0] ek4_ff, dk4_ff;
   logic signed [ForceW-1:0] f5_ff, f6_ff;
   logic [54:0]        pp6_ff [3][2];
   logic               fneg6_ff [3];
   rsp_type            rsp_ff;

   // Direction and degenerate flag travel alongside.
   logic [2:0][DirW-1:0] dir_ff [6];
   logic [2:0]           dneg_ff [6];
   logic                 deg_ff [7];

   always_ff @(posedge clock) begin
      dir_ff[0]  <= g_data.dir_mag;
      dneg_ff[0] <= g_data.dir_neg;
      deg_ff[0]  <= g_data.degenerate;
      for (int s = 1; s < 6; s++) begin
         dir_ff[s]  <= dir_ff[s-1];
         dneg_ff[s] <= dneg_ff[s-1];
      end
      for (int s = 1; s < 7; s++) deg_ff[s] <= deg_ff[s-1];
   end

   // Velocity products and stretch.
   always_ff @(posedge clock) begin
      logic [DiffW-1:0] vm;
      for (int i = 0; i < 3; i++) begin
         vm = g_data.dvel[i][DiffW-1] ? (~g_data.dvel[i] + 1'b1) : g_data.dvel[i];
         p0_ff[i]    <= vm[MagW-1:0] * g_data.dir_mag[i];
         pneg0_ff[i] <= g_data.dvel[i][DiffW-1] ^ g_data.dir_neg[i];
      end
      st0_ff <= $signed({2'b00, g_data.len}) - $signed({3'b000, rest_ff});
   end

   // Velocity along the bar.
   always_ff @(posedge clock) begin
      logic signed [35:0] acc;
      logic signed [35:0] t;
      acc = '0;
      for (int i = 0; i < 3; i++) begin
         t = $signed({3'b000, p0_ff[i][62:30]});
         acc = pneg0_ff[i] ? (acc - t) : (acc + t);
      end
      ldt1_ff <= acc;
      st1_ff  <= st0_ff;
   end

   // Partial products of the elastic and damping parts.
   always_ff @(posedge clock) begin
      logic [34:0] smag;
      logic [35:0] lmag;
      smag = st1_ff[34] ? (~st1_ff + 1'b1) : st1_ff;
      lmag = ldt1_ff[35] ? (~ldt1_ff + 1'b1) : ldt1_ff;
      ek_lo2_ff    <= stiff_ff[19:0] * smag[33:0];
      ek_hi2_ff    <= stiff_ff[39:20] * smag[33:0];
      dk_pp2_ff[0] <= coef_ff[31:0] * lmag[17:0];
      dk_pp2_ff[1] <= 50'(coef_ff[31:0] * lmag[34:18]);
      dk_pp2_ff[2] <= coef_ff[63:32] * lmag[17:0];
      dk_pp2_ff[3] <= 50'(coef_ff[63:32] * lmag[34:18]);
      eneg2_ff     <= st1_ff[34];
      dneg2_ff     <= ldt1_ff[35];
   end

   // Full products.
   always_ff @(posedge clock) begin
      ek_prod3_ff <= 74'(ek_lo2_ff) + (74'(ek_hi2_ff) << 20);
      dk_prod3_ff <= 99'(dk_pp2_ff[0]) + (99'(dk_pp2_ff[1]) << 18)
                   + (99'(dk_pp2_ff[2]) << 32) + (99'(dk_pp2_ff[3]) << 50);
      eneg3_ff    <= eneg2_ff;
      dneg3_ff    <= dneg2_ff;
   end

   // Scale, cap at 2^60 and apply signs.
   always_ff @(posedge clock) begin
      logic [65:0] esh;
      logic [74:0] dsh;
      logic [60:0] em, dm;
      esh = ek_prod3_ff[73:8];
      dsh = dk_prod3_ff[98:24];
      em  = (esh > 66'(CAP60)) ? CAP60 : esh[60:0];
      dm  = (dsh > 75'(CAP60)) ? CAP60 : dsh[60:0];
      ek4_ff <= eneg3_ff ? -$signed({1'b0, em}) : $signed({1'b0, em});
      dk4_ff <= dneg3_ff ? -$signed({1'b0, dm}) : $signed({1'b0, dm});
   end

   // Axial force with saturation.
   always_ff @(posedge clock) begin
      logic signed [62:0] sum;
      sum = 63'(ek4_ff) + 63'(dk4_ff);
      if (sum > POS48)      f5_ff <= POS_F;
      else if (sum < NEG48) f5_ff <= NEG_F;
      else                  f5_ff <= sum[ForceW-1:0];
   end

   // Node force partial products.
   always_ff @(posedge clock) begin
      logic [ForceW-1:0] fm;
      fm = f5_ff[ForceW-1] ? (~f5_ff + 1'b1) : f5_ff;
      for (int i = 0; i < 3; i++) begin
         pp6_ff[i][0] <= fm[23:0] * dir_ff[5][i];
         pp6_ff[i][1] <= fm[47:24] * dir_ff[5][i];
         fneg6_ff[i]  <= f5_ff[ForceW-1] ^ dneg_ff[5][i];
      end
      f6_ff <= f5_ff;
   end

   // Node forces and the result register.
   always_ff @(posedge clock) begin
      logic [78:0] prod;
      logic [48:0] p;
      logic [ForceW-1:0] pc, fa [3], fb [3];
      for (int i = 0; i < 3; i++) begin
         prod = 79'(pp6_ff[i][0]) + (79'(pp6_ff[i][1]) << 24);
         p    = prod[78:30];
         pc   = (p > 49'(NEG_F)) ? NEG_F : p[ForceW-1:0];
         if (fneg6_ff[i])       fa[i] = ~pc + 1'b1;
         else if (pc == NEG_F)  fa[i] = POS_F;
         else                   fa[i] = pc;
         fb[i] = (fa[i] == NEG_F) ? POS_F : (~fa[i] + 1'b1);
      end
      rsp_ff.force_a_x   <= fa[0];
      rsp_ff.force_a_y   <= fa[1];
      rsp_ff.force_a_z   <= fa[2];
      rsp_ff.force_b_x   <= fb[0];
      rsp_ff.force_b_y   <= fb[1];
      rsp_ff.force_b_z   <= fb[2];
      rsp_ff.axial_force <= f6_ff;
      rsp_ff.degenerate  <= deg_ff[6];
   end

   assign rsp_valid = v_ff[7];
   assign rsp_data  = rsp_ff;

`ifndef NO_ASSERTIONS
   a_deg_axis: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.degenerate |->
         rsp_data.force_a_y == '0 && rsp_data.force_a_z == '0)
      else $error("degenerate bar gave off-axis force");

   a_b_negates: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.force_a_x != $signed(NEG_F) |->
         rsp_data.force_b_x == -rsp_data.force_a_x)
      else $error("node B force is not the negation of node A force");

   a_zero_force: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.axial_force == '0 |->
         rsp_data.force_a_x == '0 && rsp_data.force_a_y == '0 &&
         rsp_data.force_a_z == '0)
      else $error("node force without axial force");
`endif

endmodule

/* verif/bar_spring_damper_force_top_tb.sv */
module bar_spring_damper_force_top_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import bsdf_pkg::*;

   localparam logic [CsrIdxW-1:0] CSR_UNUSED = 2'd3;
   localparam int LATENCY   = 34;
   localparam int STALL_MAX = 2000;
   localparam longint unsigned CAP60 = 64'd1 << 60;
   localparam longint unsigned CAP47 = 64'd1 << 47;
   localparam longint POS48 = 64'sh7FFF_FFFF_FFFF;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              start = 1'b0;
   logic              busy;
   req_type           req_data = '0;
   logic              rsp_valid;
   rsp_type           rsp_data;
   logic              csr_write_en = 1'b0;
   logic [CsrIdxW-1:0] csr_index = '0;
   logic [StiffW-1:0] csr_wdata = '0;

   // Shadow copy of the block's registers.
   logic [StiffW-1:0] cfg_stiff = STIFF_RESET;
   logic [DampW-1:0]  cfg_damp  = DAMP_RESET;
   logic [RestW-1:0]  cfg_rest  = REST_RESET;

   req_type pending_bars[$];
   rsp_type expected_forces[$];
   int      error_count = 0;
   int      bars_sent = 0;
   int      forces_seen = 0;
   int      degenerate_seen = 0;
   int      idle_pct = 23;
   int      stall_count = 0;

   bar_spring_damper_force_top dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_data(rsp_data), .csr_write_en(csr_write_en),
      .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always #2 clock = ~clock;

   function automatic longint sat48(longint v);
      if (v > POS48) return POS48;
      if (v < -POS48 - 1) return -POS48 - 1;
      return v;
   endfunction

   // Product shifted right, with the magnitude capped.
   function automatic longint unsigned shift_cap(logic [127:0] prod, int s,
                                                 longint unsigned cap);
      logic [127:0] q;
      q = prod >> s;
      if (q > {64'd0, cap}) return cap;
      return q[63:0];
   endfunction

   function automatic longint unsigned abs64(longint v);
      return (v < 0) ? longint'(-v) : longint'(v);
   endfunction

   // Bit-by-bit integer square root of a radicand below 2^66.
   function automatic longint unsigned bar_length(logic [127:0] n);
      logic [127:0] root;
      logic [127:0] t;
      root = '0;
      for (int b = 33; b >= 0; b--) begin
         t = root | (128'd1 << b);
         if (t * t <= n) root = t;
      end
      return root[63:0];
   endfunction

   // Spring plus damper force of one bar under the current registers.
   function automatic rsp_type bar_force(req_type r);
      longint pa[3], pb[3], va[3], vb[3];
      longint d[3], dv[3];
      longint unsigned dmag[3];
      logic dneg[3];
      logic [127:0] sumsq;
      longint unsigned len, coef, p;
      longint ldt, stretch, ek, dk, f, fa[3], fb[3];
      logic deg;
      rsp_type res;
      pa = '{longint'(r.pos_a_x), longint'(r.pos_a_y), longint'(r.pos_a_z)};
      pb = '{longint'(r.pos_b_x), longint'(r.pos_b_y), longint'(r.pos_b_z)};
      va = '{longint'(r.vel_a_x), longint'(r.vel_a_y), longint'(r.vel_a_z)};
      vb = '{longint'(r.vel_b_x), longint'(r.vel_b_y), longint'(r.vel_b_z)};
      sumsq = '0;
      for (int i = 0; i < 3; i++) begin
         d[i] = pb[i] - pa[i];
         dv[i] = vb[i] - va[i];
         sumsq += 128'(abs64(d[i])) * 128'(abs64(d[i]));
      end
      len = bar_length(sumsq);
      deg = (len == 0);
      // A bar of zero length points along x by convention.
      for (int i = 0; i < 3; i++) begin
         if (deg) begin
            dmag[i] = (i == 0) ? 64'd1 << 30 : 64'd0;
            dneg[i] = 1'b0;
         end else begin
            dmag[i] = (abs64(d[i]) << 30) / len;
            dneg[i] = (d[i] < 0) && (dmag[i] != 0);
         end
      end
      ldt = 0;
      for (int i = 0; i < 3; i++) begin
         p = (abs64(dv[i]) * dmag[i]) >> 30;
         ldt += ((dv[i] < 0) != dneg[i]) ? -longint'(p) : longint'(p);
      end
      stretch = longint'(len) - longint'({32'd0, cfg_rest});
      p = shift_cap(128'(cfg_stiff) * 128'(abs64(stretch)), 8, CAP60);
      ek = (stretch < 0) ? -longint'(p) : longint'(p);
      coef = 64'(cfg_damp) * 64'(cfg_stiff);
      p = shift_cap(128'(coef) * 128'(abs64(ldt)), 24, CAP60);
      dk = (ldt < 0) ? -longint'(p) : longint'(p);
      f = sat48(ek + dk);
      for (int i = 0; i < 3; i++) begin
         p = shift_cap(128'(abs64(f)) * 128'(dmag[i]), 30, CAP47);
         fa[i] = sat48(((f < 0) != dneg[i]) ? -longint'(p) : longint'(p));
         fb[i] = sat48(-fa[i]);
      end
      res.force_a_x = fa[0][47:0];
      res.force_a_y = fa[1][47:0];
      res.force_a_z = fa[2][47:0];
      res.force_b_x = fb[0][47:0];
      res.force_b_y = fb[1][47:0];
      res.force_b_z = fb[2][47:0];
      res.axial_force = f[47:0];
      res.degenerate = deg;
      return res;
   endfunction

   task automatic check_field(string name, logic [ForceW-1:0] exp_v, logic [ForceW-1:0] act_v);
      if (exp_v !== act_v) begin
         error_count++;
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name,
                  $signed(exp_v), $signed(act_v));
      end
   endtask

   // Append one bar to the tail of the pending list.
   task automatic add_bar(req_type r);
      pending_bars.insert(pending_bars.size(), r);
   endtask

   // Input side: accept items, predict forces and track register writes.
   always @(posedge clock) begin
      if (!reset && start && !busy) begin
         expected_forces.insert(expected_forces.size(), bar_force(pending_bars.pop_front()));
         bars_sent++;
      end
      if (!reset && csr_write_en) begin
         case (csr_index)
            CSR_STIFFNESS: cfg_stiff = csr_wdata;
            CSR_DAMPING:   cfg_damp  = csr_wdata[DampW-1:0];
            CSR_REST:      cfg_rest  = csr_wdata[RestW-1:0];
            default: ;
         endcase
      end
   end

   // Result side: compare each strobed result with the oldest prediction.
   always @(posedge clock) begin
      rsp_type e;
      if (!reset && rsp_valid) begin
         forces_seen++;
         if (expected_forces.size() == 0) begin
            error_count++;
            $display("%0t: unexpected result, expected none, actual %h", $time, rsp_data);
         end else begin
            e = expected_forces.pop_front();
            if (e.degenerate) degenerate_seen++;
            check_field("force_a_x", e.force_a_x, rsp_data.force_a_x);
            check_field("force_a_y", e.force_a_y, rsp_data.force_a_y);
            check_field("force_a_z", e.force_a_z, rsp_data.force_a_z);
            check_field("force_b_x", e.force_b_x, rsp_data.force_b_x);
            check_field("force_b_y", e.force_b_y, rsp_data.force_b_y);
            check_field("force_b_z", e.force_b_z, rsp_data.force_b_z);
            check_field("axial_force", e.axial_force, rsp_data.axial_force);
            check_field("degenerate", 48'(e.degenerate), 48'(rsp_data.degenerate));
         end
      end
   end

   // Driver: present the next pending item unless this cycle idles.
   always @(negedge clock) begin
      if (!reset && pending_bars.size() > 0 && $urandom_range(99) >= idle_pct) begin
         start <= 1'b1;
         req_data <= pending_bars[0];
      end else begin
         start <= 1'b0;
      end
   end

   // Watchdog on cycles that move nothing while work is outstanding.
   always @(posedge clock) begin
      if ((pending_bars.size() > 0 || expected_forces.size() > 0) &&
          !(start && !busy) && !rsp_valid) begin
         stall_count++;
         if (stall_count >= STALL_MAX) begin
            $display("%0t: watchdog expired", $time);
            $display("Testbench completed WITH ERRORS");
            $finish;
         end
      end else begin
         stall_count = 0;
      end
   end

   task automatic write_reg(logic [CsrIdxW-1:0] idx, logic [StiffW-1:0] val);
      @(negedge clock);
      csr_write_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(negedge clock);
      csr_write_en <= 1'b0;
   endtask

   function automatic logic signed [31:0] rnd_small(int bits);
      return $signed($urandom_range((1 << bits) - 1)) - (1 << (bits - 1));
   endfunction

   // Random bar: full-range noise, short realistic bars, or coincident nodes.
   function automatic req_type random_bar();
      req_type r;
      int mode;
      mode = $urandom_range(99);
      r = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
           $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
      if (mode >= 40) begin
         r.pos_a_x = rnd_small(26);
         r.pos_a_y = rnd_small(26);
         r.pos_a_z = rnd_small(26);
         r.pos_b_x = r.pos_a_x + rnd_small(19);
         r.pos_b_y = r.pos_a_y + rnd_small(19);
         r.pos_b_z = r.pos_a_z + rnd_small(19);
         r.vel_a_x = rnd_small(20);
         r.vel_a_y = rnd_small(20);
         r.vel_a_z = rnd_small(20);
         r.vel_b_x = rnd_small(20);
         r.vel_b_y = rnd_small(20);
         r.vel_b_z = rnd_small(20);
      end
      if (mode >= 94) begin
         r.pos_b_x = r.pos_a_x;
         r.pos_b_y = r.pos_a_y;
         r.pos_b_z = r.pos_a_z;
      end
      return r;
   endfunction

   task automatic wait_drained();
      while (pending_bars.size() > 0 || expected_forces.size() > 0) @(posedge clock);
      repeat (LATENCY + 6) @(posedge clock);
   endtask

   initial begin
      req_type r;
      logic signed [31:0] mx, mn;
      mx = 32'sh7FFF_FFFF;
      mn = 32'sh8000_0000;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed bars under the reset registers.
      r = '0; add_bar(r);
      r = '0; r.pos_b_x = 32'sd65536; add_bar(r);
      r = '0; r.pos_b_y = -32'sd65536; r.vel_b_y = 32'sd65536; add_bar(r);
      r = '0; r.pos_b_z = 32'sd131072; r.vel_a_z = 32'sd65536; add_bar(r);
      r = '{mx, mx, mx, mx, mx, mx, mn, mn, mn, mx, mx, mx}; add_bar(r);
      r = '{mn, mn, mn, mx, mx, mx, mx, mx, mx, mn, mn, mn}; add_bar(r);
      r = '{mx, mn, mx, mn, mx, mn, mn, mx, mn, mx, mn, mx}; add_bar(r);
      r = '{mn, 0, 0, mx, 0, 0, 0, 0, 0, 0, 0, 0}; add_bar(r);
      r = '{mx, mx, mx, mx, mx, mx, mn, mn, mn, mx, mx, mx}; add_bar(r);
      r = '{1, 2, 3, 1, 2, 3, 5, 5, 5, -5, -5, -5}; add_bar(r);
      r = '{0, 0, 0, 1, 0, 0, 0, 0, 0, 0, 0, 0}; add_bar(r);
      r = '{0, 0, 0, 0, -1, 1, 0, 0, 0, mx, mn, mx}; add_bar(r);
      r = '{0, 0, 0, 32'sd46341, 32'sd46341, 0, 0, 0, 0, 32'sd9999, 0, 0};
      add_bar(r);
      wait_drained();

      // Extreme stiffness and damping with a rest length of one.
      write_reg(CSR_STIFFNESS, '1);
      write_reg(CSR_DAMPING, 40'hFF_FFFF);
      write_reg(CSR_REST, 40'd1);
      r = '0; add_bar(r);
      r = '{mn, mn, mn, mx, mx, mx, mx, mx, mx, mn, mn, mn}; add_bar(r);
      r = '{0, 0, 0, 32'sd65536, 0, 0, 0, 0, 0, 32'sd65536, 0, 0}; add_bar(r);
      r = '{0, 0, 0, 0, 0, 32'sd3, 0, 0, 0, 0, 0, -32'sd7}; add_bar(r);
      r = '{mx, 0, 0, mn, 0, 0, 0, mx, 0, 0, mn, 0}; add_bar(r);
      wait_drained();

      // Random phases over a spread of register settings.
      for (int ph = 0; ph < 6; ph++) begin
         case (ph)
            0: begin
               write_reg(CSR_STIFFNESS, 40'd0);
               write_reg(CSR_DAMPING, 40'd0);
               write_reg(CSR_REST, 40'hFFFF_FFFF);
            end
            1: begin
               write_reg(CSR_STIFFNESS, STIFF_RESET);
               write_reg(CSR_DAMPING, DAMP_RESET);
               write_reg(CSR_REST, REST_RESET);
            end
            2: begin
               write_reg(CSR_STIFFNESS, '1);
               write_reg(CSR_DAMPING, 40'hFF_FFFF);
               write_reg(CSR_REST, 40'd1);
            end
            default: begin
               write_reg(CSR_STIFFNESS, {$urandom_range(255), $urandom});
               write_reg(CSR_DAMPING, 40'($urandom_range(24'hFF_FFFF)));
               write_reg(CSR_REST, 40'($urandom));
               // Writes to the unused index leave every register alone.
               write_reg(CSR_UNUSED, {$urandom_range(255), $urandom});
            end
         endcase
         idle_pct = (ph == 3) ? 0 : 23;
         for (int n = 0; n < 225; n++) add_bar(random_bar());
         wait_drained();
      end

      $display("Drove %0d bars over eight register settings;", bars_sent);
      $display("checked %0d results, %0d degenerate.", forces_seen, degenerate_seen);
      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
